>>> sv/cca_pkg.sv
// shared constants and types for the chain calculator accumulator
package cca_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  localparam int OPERAND_W = 32;
  localparam int CHAR_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int S_DATA_W  = 48;
  localparam int M_DATA_W  = 40;

  localparam logic [CHAR_W-1:0] CH_NONE = 8'd63;
  localparam logic [CHAR_W-1:0] CH_ADD  = 8'd43;
  localparam logic [CHAR_W-1:0] CH_SUB  = 8'd45;
  localparam logic [CHAR_W-1:0] CH_MUL  = 8'd42;
  localparam logic [CHAR_W-1:0] CH_DIV  = 8'd47;

  localparam logic [STATUS_W-1:0] ST_OK                 = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OPERATOR_MISPLACED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OPERAND_MISPLACED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO           = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ENDS_ON_OPERATOR   = 3'd4;

  localparam logic CMD_OPERAND  = 1'b0;
  localparam logic CMD_OPERATOR = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

endpackage

>>> sv/chain_calculator_accumulator_unit.sv
// left-to-right chain calculator with bit-serial multiply and divide
//
//  channel | dir | tdata (low bit up)                          | tuser | tlast
//  s_*     | in  | operand[31:0] op_char[39:32] first_token[40] | cmd   | last_token
//  m_*     | out | value[31:0] status[34:32]                   | -     | done_res
//
//  load, add, subtract and operator tokens go from the accepted beat into the output register, via S_EMIT if it is busy
//  multiply and divide go through accept, one bit per cycle in the
//  shared shift-add / restoring-divide loop, then the result beat
//  rst is synchronous and clears the accumulator, operator, flag, error and m_tvalid
//  a new beat is taken while one result waits in the output register
module chain_calculator_accumulator_unit
  import cca_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // operand, op_char, first_token, zero fill
  input  logic                s_tuser,   // cmd
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // value, status, zero fill
  output logic                m_tlast
);

  localparam int CNT_W = $clog2(DATA_WIDTH);

  state_t                  state;
  logic [DATA_WIDTH-1:0]   acc;
  logic [CHAR_W-1:0]       pend;
  logic                    expect_op;
  logic [STATUS_W-1:0]     err;
  logic                    last_q;

  logic [DATA_WIDTH-1:0]   sa;
  logic [DATA_WIDTH-1:0]   sb;
  logic [DATA_WIDTH:0]     work;
  logic                    neg;
  logic [CNT_W-1:0]        cnt;

  logic [DATA_WIDTH-1:0]   acc_next;
  logic [CHAR_W-1:0]       pend_next;
  logic                    expect_next;
  logic [STATUS_W-1:0]     err_next;
  logic                    go_mul;
  logic                    go_div;

  logic [DATA_WIDTH-1:0]   acc_eff;
  logic [DATA_WIDTH-1:0]   opd;
  logic [OPERAND_W-1:0]    operand_in;
  logic [CHAR_W-1:0]       op_char_in;
  logic                    first_in;
  logic signed [63:0]      opd_wide;

  logic                    accept;
  logic                    out_free;
  logic                    out_load;
  logic [DATA_WIDTH-1:0]   out_acc;
  logic [STATUS_W-1:0]     out_err;
  logic                    out_last;

  logic [DATA_WIDTH-1:0]   mul_sum;
  logic [DATA_WIDTH:0]     rs;
  logic [DATA_WIDTH:0]     diff;
  logic                    q_bit;
  logic [DATA_WIDTH-1:0]   sa_div;

  function automatic logic [DATA_WIDTH-1:0] mag(input logic [DATA_WIDTH-1:0] a);
    return a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic logic [OPERAND_W-1:0] to_out(input logic [DATA_WIDTH-1:0] a);
    logic signed [63:0] w;
    w = 64'(signed'(a));
    return w[OPERAND_W-1:0];
  endfunction

  assign operand_in = s_tdata[OPERAND_W-1:0];
  assign op_char_in = s_tdata[OPERAND_W+CHAR_W-1:OPERAND_W];
  assign first_in   = s_tdata[OPERAND_W+CHAR_W];
  assign opd_wide   = 64'(signed'(operand_in));
  assign opd        = opd_wide[DATA_WIDTH-1:0];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // token decode with first-token clear folded in
  always_comb begin
    logic [CHAR_W-1:0]   pend_eff;
    logic                exp_eff;
    logic [STATUS_W-1:0] err_eff;
    acc_eff     = first_in ? '0 : acc;
    pend_eff    = first_in ? CH_NONE : pend;
    exp_eff     = first_in ? 1'b0 : expect_op;
    err_eff     = first_in ? ST_OK : err;
    acc_next    = acc_eff;
    pend_next   = pend_eff;
    expect_next = exp_eff;
    err_next    = err_eff;
    go_mul      = 1'b0;
    go_div      = 1'b0;
    if (err_eff == ST_OK) begin
      if (s_tuser == CMD_OPERATOR) begin
        if (!exp_eff) begin
          err_next = ST_OPERATOR_MISPLACED;
        end else begin
          pend_next   = op_char_in;
          expect_next = 1'b0;
        end
      end else begin
        if (exp_eff) begin
          err_next = ST_OPERAND_MISPLACED;
        end else begin
          case (pend_eff)
            CH_NONE: acc_next = opd;
            CH_ADD:  acc_next = acc_eff + opd;
            CH_SUB:  acc_next = acc_eff - opd;
            CH_MUL:  go_mul = 1'b1;
            CH_DIV: begin
              if (opd == '0) err_next = ST_DIV_ZERO;
              else go_div = 1'b1;
            end
            default: acc_next = acc_eff;
          endcase
          if (err_next == ST_OK) expect_next = 1'b1;
        end
      end
      if (s_tlast && err_next == ST_OK && !expect_next) err_next = ST_ENDS_ON_OPERATOR;
    end
  end

  // one bit per cycle of the shared loop
  assign mul_sum = sb[0] ? (work[DATA_WIDTH-1:0] + sa) : work[DATA_WIDTH-1:0];
  assign rs      = {work[DATA_WIDTH-1:0], sa[DATA_WIDTH-1]};
  assign diff    = rs - {1'b0, sb};
  assign q_bit   = !diff[DATA_WIDTH];
  assign sa_div  = {sa[DATA_WIDTH-2:0], q_bit};

  always_comb begin
    out_load = 1'b0;
    out_acc  = acc;
    out_err  = err;
    out_last = last_q;
    if (state == S_IDLE) begin
      out_acc  = acc_next;
      out_err  = err_next;
      out_last = s_tlast;
      out_load = accept && !go_mul && !go_div && out_free;
    end else if (state == S_EMIT) begin
      out_load = out_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc       <= '0;
      pend      <= CH_NONE;
      expect_op <= 1'b0;
      err       <= ST_OK;
      last_q    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            acc       <= acc_next;
            pend      <= pend_next;
            expect_op <= expect_next;
            err       <= err_next;
            last_q    <= s_tlast;
            cnt       <= CNT_W'(DATA_WIDTH - 1);
            work      <= '0;
            if (go_mul) begin
              sa    <= acc_eff;
              sb    <= opd;
              state <= S_MUL;
            end else if (go_div) begin
              sa    <= mag(acc_eff);
              sb    <= mag(opd);
              neg   <= acc_eff[DATA_WIDTH-1] ^ opd[DATA_WIDTH-1];
              state <= S_DIV;
            end else if (!out_free) begin
              state <= S_EMIT;
            end
          end
        end
        S_MUL: begin
          work <= {1'b0, mul_sum};
          sa   <= {sa[DATA_WIDTH-2:0], 1'b0};
          sb   <= {1'b0, sb[DATA_WIDTH-1:1]};
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            acc   <= mul_sum;
            state <= S_EMIT;
          end
        end
        S_DIV: begin
          work <= q_bit ? diff : rs;
          sa   <= sa_div;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            acc   <= neg ? (~sa_div + 1'b1) : sa_div;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {(M_DATA_W - OPERAND_W - STATUS_W)'(0), out_err, to_out(out_acc)};
      m_tlast <= out_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL || state == S_DIV) |-> !s_tready)
    else $error("input ready while loop is busy");

  a_err_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(err))
    else $error("error latch changed without a beat");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (sb != '0))
    else $error("divide loop running on zero divisor");

  a_loop_ends: assert property (@(posedge clk) disable iff (rst)
    ((state == S_MUL || state == S_DIV) && cnt == '0) |=> (state == S_EMIT))
    else $error("loop did not hand over to result");
`endif

endmodule

>>> tb/sv/chain_calculator_accumulator_unit_test.sv
// testbench for the chain calculator accumulator: token stream, predicted results, checks
`timescale 1ns / 1ps

module chain_calculator_accumulator_unit_test;
  import cca_pkg::*;

  localparam int SETTLE_CYCLES = 3 * DATA_WIDTH_DEF;
  localparam int PHASE1_TOKENS = 1050;
  localparam int TOTAL_TOKENS  = 1450;

  typedef struct packed {
    logic [OPERAND_W-1:0] value;
    logic [STATUS_W-1:0]  status;
    logic                 done;
  } token_result_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;   // operand, op_char, first_token, zero fill
  logic                s_tuser;   // cmd
  logic                s_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;   // value, status, zero fill
  logic                m_tlast;

  logic [OPERAND_W-1:0] acc;
  logic [CHAR_W-1:0]    pend_op;
  logic                 want_op;
  logic [STATUS_W-1:0]  err;

  token_result_t chain_results[$];
  int tokens_sent;
  int results_checked;
  int expressions_started;
  int fail_count;
  int status_hits[8];
  bit src_idle_on;
  bit sink_idle_on;
  int stall_left;

  chain_calculator_accumulator_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("timeout with %0d results outstanding", chain_results.size());
    $display("FAIL");
    $finish;
  end

  function automatic logic [OPERAND_W-1:0] quotient_toward_zero(input logic [OPERAND_W-1:0] a,
                                                                input logic [OPERAND_W-1:0] b);
    logic [OPERAND_W-1:0] mag_a;
    logic [OPERAND_W-1:0] mag_b;
    logic [OPERAND_W-1:0] q;
    mag_a = a[OPERAND_W-1] ? -a : a;
    mag_b = b[OPERAND_W-1] ? -b : b;
    q = mag_a / mag_b;
    return (a[OPERAND_W-1] ^ b[OPERAND_W-1]) ? -q : q;
  endfunction

  function automatic void clear_chain();
    acc = '0;
    pend_op = CH_NONE;
    want_op = 1'b0;
    err = ST_OK;
  endfunction

  function automatic token_result_t apply_token(input logic cmd, input logic [OPERAND_W-1:0] opd,
                                                input logic [CHAR_W-1:0] och, input logic first,
                                                input logic last);
    token_result_t r;
    if (first) clear_chain();
    if (err == ST_OK) begin
      if (cmd == CMD_OPERATOR) begin
        if (!want_op) begin
          err = ST_OPERATOR_MISPLACED;
        end else begin
          pend_op = och;
          want_op = 1'b0;
        end
      end else if (want_op) begin
        err = ST_OPERAND_MISPLACED;
      end else begin
        case (pend_op)
          CH_NONE: acc = opd;
          CH_ADD:  acc = acc + opd;
          CH_SUB:  acc = acc - opd;
          CH_MUL:  acc = acc * opd;
          CH_DIV: begin
            if (opd == '0) err = ST_DIV_ZERO;
            else acc = quotient_toward_zero(acc, opd);
          end
          default: ;
        endcase
        if (err == ST_OK) want_op = 1'b1;
      end
      if (last && err == ST_OK && !want_op) err = ST_ENDS_ON_OPERATOR;
    end
    r.value = acc;
    r.status = err;
    r.done = last;
    return r;
  endfunction

  // one token beat; s_tvalid stays high after acceptance
  task automatic send_token(input logic cmd, input logic [OPERAND_W-1:0] opd,
                            input logic [CHAR_W-1:0] och, input logic first, input logic last);
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_DATA_W - OPERAND_W - CHAR_W - 1){1'b0}}, first, och, opd};
    s_tuser  <= cmd;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    chain_results.push_back(apply_token(cmd, opd, och, first, last));
    status_hits[chain_results[$].status]++;
    tokens_sent++;
    if (first) expressions_started++;
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (chain_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [OPERAND_W-1:0] pick_operand();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'h0000_0001;
          default: return 32'h0000_0000;
        endcase
      end
      1: return 32'($signed($urandom_range(0, 64)) - 32);
      2: return 32'($urandom_range(0, 65535));
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [OPERAND_W-1:0] pick_divisor();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return 32'($signed($urandom_range(0, 16)) - 8);
      3: return 32'h8000_0000;
      4, 5: return 32'($urandom_range(1, 1000));
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_operator();
    case ($urandom_range(0, 9))
      0, 1: return CH_ADD;
      2, 3: return CH_SUB;
      4, 5: return CH_MUL;
      6, 7: return CH_DIV;
      8: return CH_NONE;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_chain(input int n_ops);
    int k;
    logic [CHAR_W-1:0] op;
    send_token(CMD_OPERAND, pick_operand(), 8'($urandom), 1'b1, n_ops == 0);
    for (k = 0; k < n_ops; k++) begin
      op = pick_operator();
      send_token(CMD_OPERATOR, 32'($urandom), op, 1'b0, 1'b0);
      send_token(CMD_OPERAND, (op == CH_DIV) ? pick_divisor() : pick_operand(), 8'($urandom),
                 1'b0, k == n_ops - 1);
    end
  endtask

  // well-formed chain with one syntax fault, or continuing without a first token
  task automatic run_faulty_chain();
    int n;
    int fault;
    int k;
    n = $urandom_range(1, 4);
    fault = $urandom_range(0, 3);
    send_token(CMD_OPERAND, pick_operand(), 8'($urandom), fault != 3, 1'b0);
    for (k = 0; k < n; k++) begin
      send_token(CMD_OPERATOR, 32'($urandom), pick_operator(), 1'b0, 1'b0);
      if (fault == 0 && k == 0)
        send_token(CMD_OPERATOR, 32'($urandom), pick_operator(), 1'b0, 1'b0);
      send_token(CMD_OPERAND, pick_operand(), 8'($urandom), 1'b0, k == n - 1 && fault != 2);
      if (fault == 1 && k == 0)
        send_token(CMD_OPERAND, pick_operand(), 8'($urandom), 1'b0, 1'b0);
    end
    if (fault == 2) send_token(CMD_OPERATOR, 32'($urandom), pick_operator(), 1'b0, 1'b1);
  endtask

  task automatic send_noise(input int n);
    repeat (n)
      send_token(1'($urandom), 32'($urandom), 8'($urandom), $urandom_range(0, 7) == 0,
                 $urandom_range(0, 3) == 0);
  endtask

  task automatic run_random_mix(input int target);
    int pick;
    while (tokens_sent < target) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) run_chain($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 8));
      else if (pick <= 8) run_faulty_chain();
      else send_noise($urandom_range(1, 4));
    end
  endtask

  task automatic test_directed_edges();
    send_token(CMD_OPERAND, 32'd3, 8'h00, 1'b0, 1'b0);
    send_token(CMD_OPERATOR, 32'hffff_ffff, CH_ADD, 1'b0, 1'b0);
    send_token(CMD_OPERAND, 32'h7fff_ffff, 8'hff, 1'b0, 1'b0);
    send_token(CMD_OPERATOR, 32'h0, CH_SUB, 1'b0, 1'b0);
    send_token(CMD_OPERAND, 32'h8000_0000, 8'h00, 1'b0, 1'b0);
    send_token(CMD_OPERATOR, 32'h0, CH_MUL, 1'b0, 1'b0);
    send_token(CMD_OPERAND, 32'hffff_ffff, 8'h00, 1'b0, 1'b0);
    send_token(CMD_OPERATOR, 32'h0, CH_DIV, 1'b0, 1'b0);
    send_token(CMD_OPERAND, 32'h0, 8'h00, 1'b0, 1'b1);
    send_token(CMD_OPERATOR, 32'h0, CH_ADD, 1'b0, 1'b0);
    send_token(CMD_OPERAND, 32'h8000_0000, 8'h00, 1'b1, 1'b0);
    send_token(CMD_OPERATOR, 32'h0, CH_DIV, 1'b0, 1'b0);
    send_token(CMD_OPERAND, 32'hffff_ffff, 8'h00, 1'b0, 1'b1);
    send_token(CMD_OPERATOR, 32'h0, CH_ADD, 1'b1, 1'b1);
    send_token(CMD_OPERAND, -32'sd7, 8'h00, 1'b1, 1'b0);
    send_token(CMD_OPERATOR, 32'h0, CH_DIV, 1'b0, 1'b0);
    send_token(CMD_OPERAND, 32'd2, 8'h00, 1'b0, 1'b0);
    send_token(CMD_OPERAND, 32'd5, 8'h00, 1'b0, 1'b0);
    send_token(CMD_OPERAND, 32'd5, 8'h00, 1'b1, 1'b0);
    send_token(CMD_OPERATOR, 32'h0, 8'hff, 1'b0, 1'b0);
    send_token(CMD_OPERAND, 32'd7, 8'h00, 1'b0, 1'b0);
    send_token(CMD_OPERATOR, 32'h0, 8'h00, 1'b0, 1'b1);
    send_token(CMD_OPERAND, 32'd9, 8'h00, 1'b1, 1'b1);
    send_token(CMD_OPERATOR, 32'h0, CH_MUL, 1'b0, 1'b0);
    send_token(CMD_OPERAND, 32'h7fff_ffff, 8'h00, 1'b0, 1'b1);
    wait_all_results();
  endtask

  task automatic test_random_chains_with_gaps();
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    run_random_mix(PHASE1_TOKENS);
    wait_all_results();
  endtask

  task automatic test_steady_stream();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    run_random_mix(TOTAL_TOKENS);
    s_tvalid <= 1'b0;
  endtask

  task automatic finish_run();
    int waited;
    waited = 0;
    while (chain_results.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (chain_results.size() != 0) begin
      $display("%0d expected results never arrived", chain_results.size());
      fail_count += chain_results.size();
    end
    $display("%0d tokens in %0d expressions, %0d results checked", tokens_sent,
             expressions_started, results_checked);
    $display("status seen: ok %0d, op misplaced %0d, operand misplaced %0d, div zero %0d, ends on op %0d",
             status_hits[ST_OK], status_hits[ST_OPERATOR_MISPLACED],
             status_hits[ST_OPERAND_MISPLACED], status_hits[ST_DIV_ZERO],
             status_hits[ST_ENDS_ON_OPERATOR]);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  endtask

  // sink stalls in bursts
  initial begin
    m_tready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!sink_idle_on) begin
        stall_left = 0;
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    token_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (chain_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: value %h status %0d done %0b",
                   m_tdata[OPERAND_W-1:0], m_tdata[OPERAND_W+STATUS_W-1:OPERAND_W], m_tlast);
      end else begin
        exp_r = chain_results.pop_front();
        results_checked++;
        if (m_tdata[OPERAND_W-1:0] !== exp_r.value ||
            m_tdata[OPERAND_W+STATUS_W-1:OPERAND_W] !== exp_r.status ||
            m_tlast !== exp_r.done) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d mismatch: expected value %h status %0d done %0b, got %h %0d %0b",
                     results_checked, exp_r.value, exp_r.status, exp_r.done,
                     m_tdata[OPERAND_W-1:0], m_tdata[OPERAND_W+STATUS_W-1:OPERAND_W], m_tlast);
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    s_tlast <= 1'b0;
    tokens_sent = 0;
    results_checked = 0;
    expressions_started = 0;
    fail_count = 0;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    foreach (status_hits[i]) status_hits[i] = 0;
    clear_chain();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_random_chains_with_gaps();
    test_steady_stream();
    finish_run();
  end

endmodule
